>>> design/rect_tilemap_collision_defines.svh
// Assertion macros shared by the tile map collision block.
// Each macro expands to a labeled concurrent assertion on the rising clock,
// disabled while the active-low reset is asserted.
`ifndef RECT_TILEMAP_COLLISION_DEFINES_SVH
`define RECT_TILEMAP_COLLISION_DEFINES_SVH
`ifndef SYNTHESIS
`define RTC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("tile map collision: property violated");
`define RTC_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("tile map collision: forbidden condition");
`else
`define RTC_ASSERT(label, clk, rstn, prop)
`define RTC_NEVER(label, clk, rstn, expr)
`endif
`endif

>>> design/rtc_pkg.sv
package rtc_pkg;

    // Map storage limits.
    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int MAX_DIM  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // Tile index width; large enough to hold the map size and a saturated quotient.
    localparam int Q_W      = $clog2(MAX_DIM + 1);

    // Field widths.
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int COORD_W   = 16;
    localparam int SIZE_W    = 10;
    localparam int FCOL_W    = 6;
    localparam int FROW_W    = 6;
    localparam int SUM_W     = COORD_W + 2;
    localparam int DVD_W     = COORD_W;

    // Register reset values.
    localparam logic [CFG_W-1:0] TILE_WIDTH_RST  = 7'd16;
    localparam logic [CFG_W-1:0] TILE_HEIGHT_RST = 7'd16;
    localparam logic [CFG_W-1:0] MAP_COLS_RST    = 7'd64;
    localparam logic [CFG_W-1:0] MAP_ROWS_RST    = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILE_WIDTH  = 3'd0,
        CFG_TILE_HEIGHT = 3'd1,
        CFG_MAP_COLS    = 3'd2,
        CFG_MAP_ROWS    = 3'd3
    } cfg_idx_t;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_QUERY = 1'b1
    } req_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_accept;
        logic q_accept;
        logic wr_back;
        logic setup;
        logic walk;
        logic out_load;
    } rtc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_busy;
        logic range_empty;
        logic hit;
        logic walk_end;
        logic out_free;
    } rtc_sts_t;

endpackage

>>> design/rect_tilemap_collision.sv
// Rectangle versus solid tile map test.
// Input channel (s_valid/s_ready): s_req_type selects a tile write or a query.
// A write stores s_solid_in for tile (s_tile_col, s_tile_row) and gives no
// result; it reads and writes back the map row before the next item is taken.
// A query tests the pixel rectangle s_rect_left/top/width/height against the
// map and gives one item on the result channel (m_valid/m_ready, m_collides).
// A query runs the four tile index dividers, a setup step, a walk over the
// covered map rows with one map row read per cycle (ending early on a hit,
// none when the rectangle misses the map), a step to end the walk, and the
// output register load. The next item can be taken in the same cycle that
// m_valid rises.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready and
// must only be written while no item is in flight.
// Reset restores the register defaults and clears the map through per-row
// valid bits; no clearing pass is needed.
// If the receiver stalls, the result waits in the output register and the next
// item is still accepted; a following query holds before its result load.
module rect_tilemap_collision (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_req_type,
    input  logic [rtc_pkg::FCOL_W-1:0]         s_tile_col,
    input  logic [rtc_pkg::FROW_W-1:0]         s_tile_row,
    input  logic                               s_solid_in,
    input  logic signed [rtc_pkg::COORD_W-1:0] s_rect_left,
    input  logic signed [rtc_pkg::COORD_W-1:0] s_rect_top,
    input  logic [rtc_pkg::SIZE_W-1:0]         s_rect_width,
    input  logic [rtc_pkg::SIZE_W-1:0]         s_rect_height,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_collides,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rtc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rtc_pkg::CFG_W-1:0]          cfg_data
);
    import rtc_pkg::*;

    rtc_cmd_t cmd;
    rtc_sts_t sts;

    // Sequencer for tile writes and queries.
    rtc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Map storage, dividers, row walk and output register.
    rtc_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_tile_col    (s_tile_col),
        .s_tile_row    (s_tile_row),
        .s_solid_in    (s_solid_in),
        .s_rect_left   (s_rect_left),
        .s_rect_top    (s_rect_top),
        .s_rect_width  (s_rect_width),
        .s_rect_height (s_rect_height),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_collides    (m_collides)
    );

endmodule

>>> design/rtc_div.sv
module rtc_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [rtc_pkg::DVD_W-1:0]  dividend,
    input  logic [rtc_pkg::CFG_W-1:0]  divisor,
    output logic                       busy,
    output logic [rtc_pkg::Q_W-1:0]    quotient
);
    import rtc_pkg::*;

    localparam int SD_W  = CFG_W + Q_W - 1;
    localparam int W     = (DVD_W > CFG_W + Q_W) ? DVD_W : CFG_W + Q_W;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] rem_reg;
    logic [SD_W-1:0]  sd_reg;
    logic [Q_W-1:0]   q_reg;
    logic             ovf_reg;
    logic             ge;

    // One quotient bit per cycle: compare and subtract the shifted divisor.
    assign ge = W'(rem_reg) >= W'(sd_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(Q_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Quotients that do not fit in Q_W bits saturate; they lie past any map edge.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            sd_reg  <= SD_W'(divisor) << (Q_W - 1);
            q_reg   <= '0;
            ovf_reg <= W'(dividend) >= (W'(divisor) << Q_W);
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - DVD_W'(sd_reg);
            end
            q_reg  <= Q_W'({q_reg, ge});
            sd_reg <= sd_reg >> 1;
        end
    end

    assign busy     = busy_reg;
    assign quotient = ovf_reg ? '1 : q_reg;

endmodule

>>> design/rtc_datapath.sv
`include "rect_tilemap_collision_defines.svh"

module rtc_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rtc_pkg::rtc_cmd_t                 cmd,
    output rtc_pkg::rtc_sts_t                 sts,
    input  logic [rtc_pkg::FCOL_W-1:0]        s_tile_col,
    input  logic [rtc_pkg::FROW_W-1:0]        s_tile_row,
    input  logic                              s_solid_in,
    input  logic signed [rtc_pkg::COORD_W-1:0] s_rect_left,
    input  logic signed [rtc_pkg::COORD_W-1:0] s_rect_top,
    input  logic [rtc_pkg::SIZE_W-1:0]        s_rect_width,
    input  logic [rtc_pkg::SIZE_W-1:0]        s_rect_height,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rtc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rtc_pkg::CFG_W-1:0]         cfg_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_collides
);
    import rtc_pkg::*;

    localparam int EXT_W = CFG_W + Q_W;

    // Configuration registers.
    logic [CFG_W-1:0] tile_width_reg;
    logic [CFG_W-1:0] tile_height_reg;
    logic [CFG_W-1:0] map_cols_reg;
    logic [CFG_W-1:0] map_rows_reg;

    // Effective geometry.
    logic [CFG_W-1:0] tw_eff;
    logic [CFG_W-1:0] th_eff;
    logic [Q_W-1:0]   cols_eff;
    logic [Q_W-1:0]   rows_eff;
    logic [Q_W-1:0]   cols_m1;
    logic [Q_W-1:0]   rows_m1;

    // Rectangle edges and divider results.
    logic [SUM_W-1:0] right_sum;
    logic [SUM_W-1:0] bottom_sum;
    logic [3:0]       div_busy;
    logic [Q_W-1:0]   q_c0;
    logic [Q_W-1:0]   q_c1;
    logic [Q_W-1:0]   q_r0;
    logic [Q_W-1:0]   q_r1;
    logic             neg_c0_reg;
    logic             neg_c1_reg;
    logic             neg_r0_reg;
    logic             neg_r1_reg;
    logic             size_zero_reg;

    // Clamped tile range.
    logic [Q_W-1:0]      c0;
    logic [Q_W-1:0]      c1;
    logic [Q_W-1:0]      r0;
    logic [Q_W-1:0]      r1;
    logic                empty_next;
    logic [MAX_COLS-1:0] mask_next;

    // Row walk.
    logic [MAX_COLS-1:0] mask_reg;
    logic                empty_reg;
    logic [Q_W-1:0]      rw_reg;
    logic [Q_W-1:0]      r1_reg;
    logic                issue;
    logic                rd_vld_reg;
    logic                rd_last_reg;
    logic                res_reg;
    logic                hit;

    // Tile map storage and tile write.
    logic [MAX_COLS-1:0] tile_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] row_vld_reg;
    logic [ROW_W-1:0]    rd_addr;
    logic [MAX_COLS-1:0] rd_reg;
    logic                rdv_reg;
    logic [COL_W-1:0]    wcol_reg;
    logic [ROW_W-1:0]    wrow_reg;
    logic                wsolid_reg;
    logic                wen_reg;
    logic                wb_en;
    logic [MAX_COLS-1:0] wr_row;

    // Result register.
    logic m_valid_reg;
    logic m_collides_reg;

    // Configuration writes; unknown indexes are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_width_reg  <= TILE_WIDTH_RST;
            tile_height_reg <= TILE_HEIGHT_RST;
            map_cols_reg    <= MAP_COLS_RST;
            map_rows_reg    <= MAP_ROWS_RST;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_TILE_WIDTH:  tile_width_reg  <= cfg_data;
                CFG_TILE_HEIGHT: tile_height_reg <= cfg_data;
                CFG_MAP_COLS:    map_cols_reg    <= cfg_data;
                CFG_MAP_ROWS:    map_rows_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A zero tile size acts as one pixel; map sizes saturate at storage size.
    assign tw_eff   = (tile_width_reg == '0) ? CFG_W'(1) : tile_width_reg;
    assign th_eff   = (tile_height_reg == '0) ? CFG_W'(1) : tile_height_reg;
    assign cols_eff = (EXT_W'(map_cols_reg) > EXT_W'(MAX_COLS)) ?
                      Q_W'(MAX_COLS) : Q_W'(map_cols_reg);
    assign rows_eff = (EXT_W'(map_rows_reg) > EXT_W'(MAX_ROWS)) ?
                      Q_W'(MAX_ROWS) : Q_W'(map_rows_reg);
    assign cols_m1  = cols_eff - Q_W'(1);
    assign rows_m1  = rows_eff - Q_W'(1);

    // Last covered pixel on each axis, sign-extended so its sign is exact.
    assign right_sum  = SUM_W'(s_rect_left) + SUM_W'(s_rect_width) - SUM_W'(1);
    assign bottom_sum = SUM_W'(s_rect_top) + SUM_W'(s_rect_height) - SUM_W'(1);

    // Four dividers run side by side; a negative edge only needs its sign.
    rtc_div u_div_c0 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.q_accept),
        .dividend ($unsigned(s_rect_left)),
        .divisor  (tw_eff),
        .busy     (div_busy[0]),
        .quotient (q_c0)
    );

    rtc_div u_div_c1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.q_accept),
        .dividend (right_sum[DVD_W-1:0]),
        .divisor  (tw_eff),
        .busy     (div_busy[1]),
        .quotient (q_c1)
    );

    rtc_div u_div_r0 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.q_accept),
        .dividend ($unsigned(s_rect_top)),
        .divisor  (th_eff),
        .busy     (div_busy[2]),
        .quotient (q_r0)
    );

    rtc_div u_div_r1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.q_accept),
        .dividend (bottom_sum[DVD_W-1:0]),
        .divisor  (th_eff),
        .busy     (div_busy[3]),
        .quotient (q_r1)
    );

    // Capture the query signs and the write operands when an item is taken.
    always_ff @(posedge aclk) begin
        if (cmd.q_accept) begin
            neg_c0_reg    <= s_rect_left[COORD_W-1];
            neg_c1_reg    <= right_sum[SUM_W-1];
            neg_r0_reg    <= s_rect_top[COORD_W-1];
            neg_r1_reg    <= bottom_sum[SUM_W-1];
            size_zero_reg <= (s_rect_width == '0) || (s_rect_height == '0);
        end
        if (cmd.wr_accept) begin
            wcol_reg   <= COL_W'(s_tile_col);
            wrow_reg   <= ROW_W'(s_tile_row);
            wsolid_reg <= s_solid_in;
            wen_reg    <= (32'(s_tile_col) < 32'(MAX_COLS)) &&
                          (32'(s_tile_row) < 32'(MAX_ROWS));
        end
    end

    // Clamp the tile range to the map and build the column mask.
    always_comb begin
        c0 = neg_c0_reg ? '0 : q_c0;
        r0 = neg_r0_reg ? '0 : q_r0;
        c1 = (q_c1 > cols_m1) ? cols_m1 : q_c1;
        r1 = (q_r1 > rows_m1) ? rows_m1 : q_r1;
        empty_next = size_zero_reg || (cols_eff == '0) || (rows_eff == '0) ||
                     neg_c1_reg || neg_r1_reg || (c0 > c1) || (r0 > r1);
        for (int c = 0; c < MAX_COLS; c++) begin
            mask_next[c] = (Q_W'(c) >= c0) && (Q_W'(c) <= c1);
        end
    end

    // Walk the covered rows, one map row read per cycle.
    assign issue = cmd.walk && !empty_reg && (rw_reg <= r1_reg);

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            mask_reg  <= mask_next;
            empty_reg <= empty_next;
            rw_reg    <= r0;
            r1_reg    <= r1;
        end else if (issue) begin
            rw_reg <= rw_reg + Q_W'(1);
        end
        rd_last_reg <= issue && (rw_reg == r1_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= issue && !cmd.setup;
        end
    end

    assign hit = rd_vld_reg && rdv_reg && (|(rd_reg & mask_reg));

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            res_reg <= 1'b0;
        end else if (cmd.walk && hit && !empty_reg) begin
            res_reg <= 1'b1;
        end
    end

    // Map rows never written read as not solid.
    assign rd_addr = cmd.walk ? rw_reg[ROW_W-1:0] : wrow_reg;
    assign wb_en   = cmd.wr_back && wen_reg;

    always_comb begin
        wr_row           = rdv_reg ? rd_reg : '0;
        wr_row[wcol_reg] = wsolid_reg;
    end

    always_ff @(posedge aclk) begin
        rd_reg  <= tile_mem[rd_addr];
        rdv_reg <= row_vld_reg[rd_addr];
        if (wb_en) begin
            tile_mem[wrow_reg] <= wr_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
        end else if (wb_en) begin
            row_vld_reg[wrow_reg] <= 1'b1;
        end
    end

    // Output register; holds the result until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_collides_reg <= res_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_collides = m_collides_reg;

    assign sts.div_busy    = |div_busy;
    assign sts.range_empty = empty_reg;
    assign sts.hit         = hit;
    assign sts.walk_end    = rd_vld_reg && rd_last_reg;
    assign sts.out_free    = !m_valid_reg || m_ready;

    // The last read of a walk is always a real read.
    `RTC_ASSERT(a_last_is_read, aclk, aresetn, rd_last_reg |-> rd_vld_reg)
    // A written tile's row is marked as holding data from then on.
    `RTC_ASSERT(a_wb_marks_row, aclk, aresetn, wb_en |=> row_vld_reg[wrow_reg])
    // No row past the clamped bottom edge is ever read during a walk.
    `RTC_ASSERT(a_walk_bound, aclk, aresetn, rd_vld_reg |-> ($past(rw_reg) <= r1_reg))

endmodule

>>> design/rtc_ctrl.sv
`include "rect_tilemap_collision_defines.svh"

module rtc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  rtc_pkg::rtc_sts_t  sts,
    output rtc_pkg::rtc_cmd_t  cmd
);
    import rtc_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_WR_RD   = 7'b0000010,
        ST_WR_WB   = 7'b0000100,
        ST_Q_DIV   = 7'b0001000,
        ST_Q_SETUP = 7'b0010000,
        ST_Q_WALK  = 7'b0100000,
        ST_Q_OUT   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_req_type == REQ_QUERY) ? ST_Q_DIV : ST_WR_RD;
                end
            end
            ST_WR_RD:   state_next = ST_WR_WB;
            ST_WR_WB:   state_next = ST_IDLE;
            ST_Q_DIV: begin
                if (!sts.div_busy) begin
                    state_next = ST_Q_SETUP;
                end
            end
            ST_Q_SETUP: state_next = ST_Q_WALK;
            ST_Q_WALK: begin
                if (sts.range_empty || sts.hit || sts.walk_end) begin
                    state_next = ST_Q_OUT;
                end
            end
            ST_Q_OUT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Commands to the datapath.
    assign cmd.wr_accept = accept && (s_req_type == REQ_WRITE);
    assign cmd.q_accept  = accept && (s_req_type == REQ_QUERY);
    assign cmd.wr_back   = (state_reg == ST_WR_WB);
    assign cmd.setup     = (state_reg == ST_Q_SETUP);
    assign cmd.walk      = (state_reg == ST_Q_WALK);
    assign cmd.out_load  = (state_reg == ST_Q_OUT) && sts.out_free;

    // A query starts the dividers in the same edge that the item is taken.
    `RTC_ASSERT(a_query_starts_div, aclk, aresetn, cmd.q_accept |=> (state_reg == ST_Q_DIV) && sts.div_busy)
    // A tile write reads, writes back and returns to idle in fixed steps.
    `RTC_ASSERT(a_write_seq, aclk, aresetn, cmd.wr_accept |=> (state_reg == ST_WR_RD) ##1 (state_reg == ST_WR_WB) ##1 s_ready)
    // A finished query waits while the output register is still full.
    `RTC_ASSERT(a_out_wait, aclk, aresetn, (state_reg == ST_Q_OUT) && !sts.out_free |=> (state_reg == ST_Q_OUT))

endmodule
